### hdl/fbpa_pkg.sv
// Shared types and constants for the fixed-size chunk pool allocator.
// No dependencies; used by fbpa_link_store and fixed_block_pool_allocator_core.
package fbpa_pkg;

  localparam int unsigned MAX_CHUNKS  = 256;
  localparam int unsigned NODE_BYTES  = 16;
  localparam int unsigned IDX_W       = 8;   // chunk index field width
  localparam int unsigned CNT_W       = 9;   // chunk count / free count width
  localparam int unsigned BYTES_W     = 16;  // chunk_bytes register width
  localparam int unsigned OFFS_W      = 25;  // byte offset field width
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned LINK_ADDR_W = $clog2(MAX_CHUNKS);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_COUNT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_BYTES = CFG_IDX_W'(1);

  localparam logic [CNT_W-1:0]   CHUNK_COUNT_RST = CNT_W'(256);
  localparam logic [BYTES_W-1:0] CHUNK_BYTES_RST = BYTES_W'(64);

  typedef enum logic {
    REQ_ALLOC = 1'b0,
    REQ_FREE  = 1'b1
  } req_type_e;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_EMPTY     = 2'd1,
    STATUS_RANGE     = 2'd2,
    STATUS_NOT_ALLOC = 2'd3
  } status_e;

  typedef struct packed {
    req_type_e        req_type;
    logic [IDX_W-1:0] chunk_index;
  } req_t;

  typedef struct packed {
    status_e           status;
    logic [IDX_W-1:0]  alloc_index;
    logic [OFFS_W-1:0] alloc_offset;
    logic [CNT_W-1:0]  free_count;
  } rsp_t;

  // Write and read port of the link store
  typedef struct packed {
    logic                   we;
    logic [LINK_ADDR_W-1:0] waddr;
    logic [IDX_W-1:0]       wdata;
    logic [LINK_ADDR_W-1:0] raddr;
  } link_cmd_t;

endpackage

### hdl/fbpa_link_store.sv
// Free-list link store: one write port, one read port, registered read data.
// Depends on fbpa_pkg.
module fbpa_link_store (
  input  logic                       clk_i,
  input  fbpa_pkg::link_cmd_t        cmd_i,
  output logic [fbpa_pkg::IDX_W-1:0] rdata_o
);

  logic [fbpa_pkg::IDX_W-1:0] mem [fbpa_pkg::MAX_CHUNKS];
  logic [fbpa_pkg::IDX_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.we) begin
      mem[cmd_i.waddr] <= cmd_i.wdata;
    end
    rdata_q <= mem[cmd_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/fixed_block_pool_allocator_core.sv
// Top level of the fixed-size chunk pool allocator.
// Depends on fbpa_pkg and fbpa_link_store.
//
// Each request (allocate or free) gives exactly one result. An allocate
// served from the never-used watermark, an allocate on an empty pool and a
// free of an index out of range are answered from S_IDLE. An allocate that
// pops the free list passes through S_POP, since the link of the list head
// comes out of the registered link store before the new head is known. A
// free of an index in range passes through S_FREE, since the in-use mark of
// the chunk comes out of a registered memory before the free is checked.
// Results wait in an output register, and the next request is taken as soon
// as that register is empty or being drained and no pop or free is in progress.
// A configuration write reinitializes the pool at once; the link store is
// never cleared, as only entries written by a free are ever read back. The
// in-use marks are not cleared either: every chunk at or above the watermark
// has been handed out since the last reinit, so its mark has been written,
// and a chunk below the watermark is free by definition.
module fixed_block_pool_allocator_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [fbpa_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [fbpa_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  fbpa_pkg::req_t                  in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output fbpa_pkg::rsp_t                  out_data_o
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_POP  = 3'b010,
    S_FREE = 3'b100
  } state_e;

  localparam int unsigned IW = fbpa_pkg::IDX_W;
  localparam int unsigned CW = fbpa_pkg::CNT_W;
  localparam int unsigned MW = fbpa_pkg::OFFS_W - IW;  // multiplicand width

  state_e                          state_q, state_d;
  logic [CW-1:0]                   chunk_count_q, chunk_count_d;
  logic [fbpa_pkg::BYTES_W-1:0]    chunk_bytes_q, chunk_bytes_d;
  logic [IW-1:0]                   head_q, head_d;
  logic                            nonempty_q, nonempty_d;
  logic [CW-1:0]                   untouched_q, untouched_d;
  logic [CW-1:0]                   free_total_q, free_total_d;
  logic [IW-1:0]                   pop_idx_q, pop_idx_d;
  logic [IW-1:0]                   free_idx_q, free_idx_d;
  logic                            out_valid_q, out_valid_d;
  fbpa_pkg::rsp_t                  rsp_q, rsp_d;

  logic                            in_use_mem [fbpa_pkg::MAX_CHUNKS];
  logic                            in_use_rd_q;
  logic                            in_use_we;
  logic [IW-1:0]                   in_use_waddr;
  logic                            in_use_wdata;

  fbpa_pkg::link_cmd_t             link_cmd;
  logic [IW-1:0]                   link_rdata;

  logic                            accept;
  logic                            reinit;
  logic [CW-1:0]                   eff_count;
  logic                            load_rsp;
  fbpa_pkg::status_e               rsp_status;
  logic                            rsp_ok;
  logic [IW-1:0]                   got_idx;
  logic [CW-1:0]                   ft_minus;
  logic [fbpa_pkg::OFFS_W-1:0]     offset;

  fbpa_link_store u_link_store (
    .clk_i   (clk_i),
    .cmd_i   (link_cmd),
    .rdata_o (link_rdata)
  );

  assign in_stall_o  = !((state_q == S_IDLE) && (!out_valid_q || !out_stall_i));
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = rsp_q;

  // Chunk counts above the pool size clamp to the pool size
  assign eff_count = (chunk_count_q > CW'(fbpa_pkg::MAX_CHUNKS)) ?
                     CW'(fbpa_pkg::MAX_CHUNKS) : chunk_count_q;
  assign ft_minus  = free_total_q - CW'(1);

  assign offset = fbpa_pkg::OFFS_W'(
                    {{MW{1'b0}}, got_idx} *
                    (MW'(chunk_bytes_q) + MW'(fbpa_pkg::NODE_BYTES))
                  ) + fbpa_pkg::OFFS_W'(fbpa_pkg::NODE_BYTES);

  always_comb begin
    state_d       = state_q;
    chunk_count_d = chunk_count_q;
    chunk_bytes_d = chunk_bytes_q;
    head_d        = head_q;
    nonempty_d    = nonempty_q;
    untouched_d   = untouched_q;
    free_total_d  = free_total_q;
    pop_idx_d     = pop_idx_q;
    free_idx_d    = free_idx_q;
    in_use_we     = 1'b0;
    in_use_waddr  = pop_idx_q;
    in_use_wdata  = 1'b1;
    reinit        = 1'b0;
    load_rsp      = 1'b0;
    rsp_status    = fbpa_pkg::STATUS_OK;
    rsp_ok        = 1'b0;
    got_idx       = pop_idx_q;
    link_cmd      = '{we: 1'b0, waddr: free_idx_q,
                      wdata: head_q, raddr: head_q};

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (in_data_i.req_type == fbpa_pkg::REQ_ALLOC) begin
            if (nonempty_q) begin
              // read the head's link now, finish the pop next cycle
              pop_idx_d = head_q;
              state_d   = S_POP;
            end else if (untouched_q != '0) begin
              got_idx      = IW'(untouched_q - CW'(1));
              untouched_d  = untouched_q - CW'(1);
              free_total_d = ft_minus;
              in_use_we    = 1'b1;
              in_use_waddr = got_idx;
              load_rsp     = 1'b1;
              rsp_ok       = 1'b1;
            end else begin
              load_rsp   = 1'b1;
              rsp_status = fbpa_pkg::STATUS_EMPTY;
            end
          end else begin
            if ({1'b0, in_data_i.chunk_index} >= eff_count) begin
              load_rsp   = 1'b1;
              rsp_status = fbpa_pkg::STATUS_RANGE;
            end else begin
              // read the chunk's in-use mark now, finish the free next cycle
              free_idx_d = in_data_i.chunk_index;
              state_d    = S_FREE;
            end
          end
        end
      end
      S_POP: begin
        head_d       = link_rdata;
        free_total_d = ft_minus;
        nonempty_d   = (ft_minus != untouched_q);
        in_use_we    = 1'b1;
        load_rsp     = 1'b1;
        rsp_ok       = 1'b1;
        state_d      = S_IDLE;
      end
      S_FREE: begin
        load_rsp = 1'b1;
        // a chunk below the watermark was never handed out; its mark is stale
        if (({1'b0, free_idx_q} < untouched_q) || !in_use_rd_q) begin
          rsp_status = fbpa_pkg::STATUS_NOT_ALLOC;
        end else begin
          // push onto the free list
          in_use_we    = 1'b1;
          in_use_waddr = free_idx_q;
          in_use_wdata = 1'b0;
          link_cmd.we  = 1'b1;
          head_d       = free_idx_q;
          nonempty_d   = 1'b1;
          free_total_d = free_total_q + CW'(1);
        end
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (cfg_we_i) begin
      unique case (cfg_index_i)
        fbpa_pkg::CFG_CHUNK_COUNT: begin
          chunk_count_d = CW'(cfg_wdata_i);
          reinit        = 1'b1;
        end
        fbpa_pkg::CFG_CHUNK_BYTES: begin
          chunk_bytes_d = cfg_wdata_i;
          reinit        = 1'b1;
        end
        default: begin
        end
      endcase
    end

    if (reinit) begin
      head_d       = '0;
      nonempty_d   = 1'b0;
      untouched_d  = (chunk_count_d > CW'(fbpa_pkg::MAX_CHUNKS)) ?
                     CW'(fbpa_pkg::MAX_CHUNKS) : chunk_count_d;
      free_total_d = untouched_d;
    end
  end

  always_comb begin
    rsp_d              = rsp_q;
    rsp_d.status       = rsp_status;
    rsp_d.alloc_index  = rsp_ok ? got_idx : '0;
    rsp_d.alloc_offset = rsp_ok ? offset : '0;
    rsp_d.free_count   = free_total_d;

    out_valid_d = out_valid_q;
    if (load_rsp) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      chunk_count_q <= fbpa_pkg::CHUNK_COUNT_RST;
      chunk_bytes_q <= fbpa_pkg::CHUNK_BYTES_RST;
      head_q        <= '0;
      nonempty_q    <= 1'b0;
      untouched_q   <= fbpa_pkg::CHUNK_COUNT_RST;
      free_total_q  <= fbpa_pkg::CHUNK_COUNT_RST;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      chunk_count_q <= chunk_count_d;
      chunk_bytes_q <= chunk_bytes_d;
      head_q        <= head_d;
      nonempty_q    <= nonempty_d;
      untouched_q   <= untouched_d;
      free_total_q  <= free_total_d;
      out_valid_q   <= out_valid_d;
    end
  end

  // In-use marks: one write port, one read port, registered read data
  always_ff @(posedge clk_i) begin
    if (in_use_we) begin
      in_use_mem[in_use_waddr] <= in_use_wdata;
    end
    in_use_rd_q <= in_use_mem[in_data_i.chunk_index];
  end

  always_ff @(posedge clk_i) begin
    pop_idx_q  <= pop_idx_d;
    free_idx_q <= free_idx_d;
    if (load_rsp) begin
      rsp_q <= rsp_d;
    end
  end

endmodule
